### hw/rtl/spiq_pkg.sv
// ----------------------------------------------------------------------------
// spiq_pkg
// Shared types and constants for the stable priority insert queue.
// ----------------------------------------------------------------------------
package spiq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam int TAG_W  = 16;
  localparam int ARR_W  = 16;
  localparam int PRIO_W = 4;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DUMP   = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_ENTRY  = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ARR_W-1:0]  arrival;
    logic [PRIO_W-1:0] prio;
  } entry_t;

endpackage

### hw/rtl/spiq_if.sv
// ----------------------------------------------------------------------------
// spiq_req_if / spiq_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface spiq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [spiq_pkg::TAG_W-1:0]  entry_tag;
  logic [spiq_pkg::ARR_W-1:0]  arrival_num;
  logic [spiq_pkg::PRIO_W-1:0] prio_level;

  modport source (output valid, req_type, entry_tag, arrival_num, prio_level,
                  input ready);
  modport sink   (input valid, req_type, entry_tag, arrival_num, prio_level,
                  output ready);
endinterface

interface spiq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [spiq_pkg::TAG_W-1:0]  out_tag;
  logic [spiq_pkg::ARR_W-1:0]  out_arrival;
  logic [spiq_pkg::PRIO_W-1:0] out_prio;
  logic                        last;

  modport source (output valid, status, out_tag, out_arrival, out_prio, last,
                  input ready);
  modport sink   (input valid, status, out_tag, out_arrival, out_prio, last,
                  output ready);
endinterface

### hw/rtl/stable_priority_insert_queue_core.sv
// ----------------------------------------------------------------------------
// stable_priority_insert_queue_core
// Bounded sorted queue with stable insert and in-order dump.
// ----------------------------------------------------------------------------
// Entries live in a CAPACITY-deep memory kept sorted by priority, ties in
// arrival order. An insert walks down from the tail with one priority
// comparator and one read/write port, moving each larger-priority entry up
// by one slot per cycle, then writes the new entry into the freed slot.
// Full inserts, inserts into an empty store and empty dumps are settled
// without a walk and go straight to the response state. A dump reads the
// stored entries in order, one result per cycle while the output is not
// stalled, set by the single memory read port. One item is worked on at a
// time; the next item is taken while the last result still sits in the output register.
module stable_priority_insert_queue_core (
  input  logic          clk,
  input  logic          rst,
  spiq_req_if.sink      req,
  spiq_rsp_if.source    rsp
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_DUMP = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t                         state, state_next;
  logic [spiq_pkg::CNT_W-1:0]     count, count_next;
  logic [spiq_pkg::IDX_W-1:0]     idx, idx_next;
  spiq_pkg::entry_t               new_e, new_e_next;
  spiq_pkg::status_t              res, res_next;

  spiq_pkg::entry_t               mem [spiq_pkg::CAPACITY];
  spiq_pkg::entry_t               rd_data, wr_data, in_e;
  logic [spiq_pkg::IDX_W-1:0]     rd_addr, wr_addr;
  logic                           we;

  logic                           ovalid;
  spiq_pkg::status_t              ostatus;
  spiq_pkg::entry_t               oentry;
  logic                           olast;
  logic                           load;
  spiq_pkg::status_t              ld_status;
  spiq_pkg::entry_t               ld_entry;
  logic                           ld_last;

  logic out_free;
  logic accept;
  logic dump_last;

  assign out_free  = !ovalid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_e      = '{tag: req.entry_tag, arrival: req.arrival_num,
                       prio: req.prio_level};
  assign dump_last = ({1'b0, idx} + (spiq_pkg::IDX_W + 1)'(1))
                     == (spiq_pkg::IDX_W + 1)'(count);

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    new_e_next = new_e;
    res_next   = res;
    rd_addr    = idx;
    wr_addr    = idx;
    wr_data    = new_e;
    we         = 1'b0;
    load       = 1'b0;
    ld_status  = res;
    ld_entry   = '0;
    ld_last    = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == spiq_pkg::REQ_INSERT) begin
            new_e_next = in_e;
            if (count == spiq_pkg::CNT_W'(spiq_pkg::CAPACITY)) begin
              res_next   = spiq_pkg::ST_FULL;
              state_next = S_RESP;
            end else if (count == '0) begin
              we         = 1'b1;
              wr_addr    = '0;
              wr_data    = in_e;
              count_next = spiq_pkg::CNT_W'(1);
              res_next   = spiq_pkg::ST_ACCEPT;
              state_next = S_RESP;
            end else begin
              // start at the tail: compare against the last stored entry
              idx_next   = spiq_pkg::IDX_W'(count);
              rd_addr    = spiq_pkg::IDX_W'(count - spiq_pkg::CNT_W'(1));
              state_next = S_INS;
            end
          end else begin
            if (count == '0) begin
              res_next   = spiq_pkg::ST_EMPTY;
              state_next = S_RESP;
            end else begin
              idx_next   = '0;
              rd_addr    = '0;
              state_next = S_DUMP;
            end
          end
        end
      end

      S_INS: begin
        we = 1'b1;
        if (rd_data.prio > new_e.prio) begin
          // move entry up one slot, keep walking down
          wr_data = rd_data;
          if (idx == spiq_pkg::IDX_W'(1)) begin
            idx_next   = '0;
            state_next = S_PUT;
          end else begin
            idx_next = idx - spiq_pkg::IDX_W'(1);
            rd_addr  = idx - spiq_pkg::IDX_W'(2);
          end
        end else begin
          wr_data    = new_e;
          count_next = count + spiq_pkg::CNT_W'(1);
          res_next   = spiq_pkg::ST_ACCEPT;
          state_next = S_RESP;
        end
      end

      S_PUT: begin
        we         = 1'b1;
        wr_data    = new_e;
        count_next = count + spiq_pkg::CNT_W'(1);
        res_next   = spiq_pkg::ST_ACCEPT;
        state_next = S_RESP;
      end

      S_DUMP: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = spiq_pkg::ST_ENTRY;
          ld_entry  = rd_data;
          ld_last   = dump_last;
          if (dump_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + spiq_pkg::IDX_W'(1);
            rd_addr  = idx + spiq_pkg::IDX_W'(1);
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    new_e <= new_e_next;
    res   <= res_next;
    if (load) begin
      ostatus <= ld_status;
      oentry  <= ld_entry;
      olast   <= ld_last;
    end
  end

  assign rsp.valid       = ovalid;
  assign rsp.status      = ostatus;
  assign rsp.out_tag     = oentry.tag;
  assign rsp.out_arrival = oentry.arrival;
  assign rsp.out_prio    = oentry.prio;
  assign rsp.last        = olast;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spiq_pkg::CNT_W'(spiq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == spiq_pkg::REQ_INSERT &&
    count == spiq_pkg::CNT_W'(spiq_pkg::CAPACITY) |=> state == S_RESP && $stable(count))
    else $error("insert into full store changed the count");

  a_dump_mid: assert property (@(posedge clk) disable iff (rst)
    load && ld_status == spiq_pkg::ST_ENTRY && !ld_last |=> state == S_DUMP)
    else $error("dump ended before its last entry");

endmodule
